// ===== rtl/cbm_pkg.sv =====
// package for the cartridge bank mapper (2K graphics pairs)
// types, constants and command/status structs shared by the top, cfg, ctrl, mod and dp rtl files
// no dependencies
package cbm_pkg;

    localparam int unsigned BANK_W        = 8;
    localparam int unsigned NUM_REGS      = 8;
    localparam int unsigned REG_IDX_W     = $clog2(NUM_REGS);
    localparam int unsigned NUM_PAIRS     = 4;
    localparam int unsigned PAIR_W        = $clog2(NUM_PAIRS);
    localparam int unsigned NUM_SLOTS     = 2 * NUM_PAIRS;

    // cpu write offsets
    localparam logic [BANK_W-1:0] ADDR_SELECT = 8'h00;
    localparam logic [BANK_W-1:0] ADDR_DATA   = 8'h01;

    // bank register roles
    localparam logic [REG_IDX_W-1:0] REG_MIRROR = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_PRG    = 3'd5;

    // mirroring codes
    localparam logic [1:0] MIRROR_VERT = 2'd0;
    localparam logic [1:0] MIRROR_HORZ = 2'd1;
    localparam logic [1:0] MIRROR_FOUR = 2'd2;

    // remainder unit: 9-bit dividend, three dividend bits per step
    localparam int unsigned DVD_W         = BANK_W + 1;
    localparam int unsigned BITS_PER_STEP = 3;
    localparam int unsigned STEPS_PER_OP  = DVD_W / BITS_PER_STEP;
    localparam int unsigned STEP_W        = $clog2(STEPS_PER_OP);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(STEPS_PER_OP - 1);

    // remainder operations: program bank first, then one per graphics pair
    localparam int unsigned NUM_OPS = 1 + NUM_PAIRS;
    localparam int unsigned OP_W    = $clog2(NUM_OPS);
    localparam logic [OP_W-1:0] OP_PRG  = OP_W'(0);
    localparam logic [OP_W-1:0] OP_LAST = OP_W'(NUM_OPS - 1);

    // configuration port
    localparam int unsigned CFG_ADDR_W = 4;
    localparam int unsigned CFG_DATA_W = 32;
    localparam logic [1:0] CFG_PRG_CNT  = 2'd0;
    localparam logic [1:0] CFG_CHR_CNT  = 2'd1;
    localparam logic [1:0] CFG_QUAD_SCR = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [BANK_W-1:0] prg_banks;
        logic [BANK_W-1:0] chr_banks;
        logic              quad_screen;
    } t_cfg;

    typedef struct packed {
        logic            accept;
        logic            step;
        logic            first;
        logic            store;
        logic            emit;
        logic [OP_W-1:0] op;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

    typedef struct packed {
        logic                               map_updated;
        logic [BANK_W-1:0]                  prg_switch_bank;
        logic [BANK_W-1:0]                  prg_fixed_bank;
        logic [NUM_SLOTS-1:0][BANK_W-1:0]   chr_slot;
        logic [1:0]                         mirror_mode;
    } t_result;

endpackage

// ===== rtl/cbm_if.sv =====
// valid/ready channel interfaces for the bank mapper
// cbm_in_if carries cpu writes, cbm_out_if carries the bank map; no dependencies
interface cbm_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] addr_low;
    logic [7:0] write_data;

    modport source (output valid, output addr_low, output write_data, input ready);
    modport sink   (input valid, input addr_low, input write_data, output ready);
endinterface

interface cbm_out_if;
    logic       valid;
    logic       ready;
    logic       map_updated;
    logic [7:0] prg_switch_bank;
    logic [7:0] prg_fixed_bank;
    logic [7:0] chr_slot0;
    logic [7:0] chr_slot1;
    logic [7:0] chr_slot2;
    logic [7:0] chr_slot3;
    logic [7:0] chr_slot4;
    logic [7:0] chr_slot5;
    logic [7:0] chr_slot6;
    logic [7:0] chr_slot7;
    logic [1:0] mirror_mode;

    modport source (
        output valid, output map_updated, output prg_switch_bank, output prg_fixed_bank,
        output chr_slot0, output chr_slot1, output chr_slot2, output chr_slot3,
        output chr_slot4, output chr_slot5, output chr_slot6, output chr_slot7,
        output mirror_mode, input ready
    );
    modport sink (
        input valid, input map_updated, input prg_switch_bank, input prg_fixed_bank,
        input chr_slot0, input chr_slot1, input chr_slot2, input chr_slot3,
        input chr_slot4, input chr_slot5, input chr_slot6, input chr_slot7,
        input mirror_mode, output ready
    );
endinterface

// ===== rtl/cartridge_bank_mapper_2k_chr.sv =====
// a write transfer is taken only while idle; the shared remainder unit then works
//   out five remainders at three dividend bits per cycle, and the map is loaded into the
//   output register once that register is free, after which the next write can be taken
// reset: i_rst_n synchronous active low; bank registers and select clear to 0,
//   counts return to 2 program / 8 graphics banks, four-screen off
// top level of the bank mapper; depends on cbm_pkg, cbm_if, cbm_cfg, cbm_ctrl, cbm_dp
module cartridge_bank_mapper_2k_chr (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    cbm_in_if.sink                           i_in,
    cbm_out_if.source                        o_out,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [cbm_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [cbm_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [cbm_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import cbm_pkg::*;

    t_cfg       w_cfg;
    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    t_result    w_result;

    cbm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    cbm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    cbm_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_cfg        (w_cfg),
        .i_addr_low   (i_in.addr_low),
        .i_write_data (i_in.write_data),
        .o_out_valid  (o_out.valid),
        .i_out_ready  (o_out.ready),
        .o_result     (w_result)
    );

    assign o_out.map_updated     = w_result.map_updated;
    assign o_out.prg_switch_bank = w_result.prg_switch_bank;
    assign o_out.prg_fixed_bank  = w_result.prg_fixed_bank;
    assign o_out.chr_slot0       = w_result.chr_slot[0];
    assign o_out.chr_slot1       = w_result.chr_slot[1];
    assign o_out.chr_slot2       = w_result.chr_slot[2];
    assign o_out.chr_slot3       = w_result.chr_slot[3];
    assign o_out.chr_slot4       = w_result.chr_slot[4];
    assign o_out.chr_slot5       = w_result.chr_slot[5];
    assign o_out.chr_slot6       = w_result.chr_slot[6];
    assign o_out.chr_slot7       = w_result.chr_slot[7];
    assign o_out.mirror_mode     = w_result.mirror_mode;

endmodule

// ===== rtl/cbm_cfg.sv =====
// apb-style configuration registers of the bank mapper
// depends on cbm_pkg
module cbm_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [cbm_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [cbm_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [cbm_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                             pready,
    output cbm_pkg::t_cfg                    o_cfg
);
    import cbm_pkg::*;

    t_cfg       r_cfg;
    logic       w_wr;
    logic [1:0] w_idx;

    assign pready = 1'b1;
    assign w_idx  = paddr[3:2];
    assign w_wr   = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prg_banks   <= 8'd2;
            r_cfg.chr_banks   <= 8'd8;
            r_cfg.quad_screen <= 1'b0;
        end else if (w_wr) begin
            case (w_idx)
                CFG_PRG_CNT:  r_cfg.prg_banks   <= pwdata[BANK_W-1:0];
                CFG_CHR_CNT:  r_cfg.chr_banks   <= pwdata[BANK_W-1:0];
                CFG_QUAD_SCR: r_cfg.quad_screen <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            CFG_PRG_CNT:  prdata = {{(CFG_DATA_W-BANK_W){1'b0}}, r_cfg.prg_banks};
            CFG_CHR_CNT:  prdata = {{(CFG_DATA_W-BANK_W){1'b0}}, r_cfg.chr_banks};
            CFG_QUAD_SCR: prdata = {{(CFG_DATA_W-1){1'b0}}, r_cfg.quad_screen};
            default:      prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/cbm_ctrl.sv =====
// controller of the bank mapper: accepts a write, sequences the remainder
// operations and hands the map to the output register; depends on cbm_pkg
module cbm_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  cbm_pkg::t_dp_status   i_status,
    output cbm_pkg::t_dp_cmd      o_cmd
);
    import cbm_pkg::*;

    t_state            r_state, n_state;
    logic [OP_W-1:0]   r_op, n_op;
    logic [STEP_W-1:0] r_step, n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_op    <= OP_PRG;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_step       = r_step;
        o_in_ready   = 1'b0;
        o_cmd        = '0;
        o_cmd.op     = r_op;
        case (r_state)
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    n_state = ST_RUN;
                    n_op    = OP_PRG;
                    n_step  = '0;
                end
            end
            ST_RUN: begin
                o_cmd.step  = 1'b1;
                o_cmd.first = (r_step == '0);
                o_cmd.store = (r_step == STEP_LAST);
                if (r_step == STEP_LAST) begin
                    n_step = '0;
                    if (r_op == OP_LAST) begin
                        n_state = ST_EMIT;
                    end else begin
                        n_op = OP_W'(r_op + 1'b1);
                    end
                end else begin
                    n_step = STEP_W'(r_step + 1'b1);
                end
            end
            ST_EMIT: begin
                o_cmd.emit = i_status.out_free;
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/cbm_mod.sv =====
// iterative remainder unit, restoring, three dividend bits per step
// depends on cbm_pkg
module cbm_mod (
    input  logic                        i_clk,
    input  logic                        i_step,
    input  logic                        i_first,
    input  logic [cbm_pkg::DVD_W-1:0]   i_dividend,
    input  logic [cbm_pkg::BANK_W-1:0]  i_divisor,
    output logic [cbm_pkg::BANK_W-1:0]  o_rem
);
    import cbm_pkg::*;

    logic [BANK_W-1:0] r_rem, n_rem;
    logic [DVD_W-1:0]  r_dvd, n_dvd;

    always_comb begin
        logic [BANK_W:0] w_t;
        n_rem = i_first ? '0 : r_rem;
        n_dvd = i_first ? i_dividend : r_dvd;
        w_t   = '0;
        for (int k = 0; k < BITS_PER_STEP; k++) begin
            w_t   = {n_rem, n_dvd[DVD_W-1]};
            n_dvd = {n_dvd[DVD_W-2:0], 1'b0};
            if (w_t >= {1'b0, i_divisor}) begin
                w_t = w_t - {1'b0, i_divisor};
            end
            n_rem = w_t[BANK_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_rem <= n_rem;
            r_dvd <= n_dvd;
        end
    end

    // final remainder is valid in the last step cycle of an operation
    assign o_rem = n_rem;

endmodule

// ===== rtl/cbm_dp.sv =====
// datapath of the bank mapper: bank registers, remainder unit, result
// registers and output register; depends on cbm_pkg and cbm_mod
module cbm_dp (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  cbm_pkg::t_dp_cmd         i_cmd,
    output cbm_pkg::t_dp_status      o_status,
    input  cbm_pkg::t_cfg            i_cfg,
    input  logic [7:0]               i_addr_low,
    input  logic [7:0]               i_write_data,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output cbm_pkg::t_result         o_result
);
    import cbm_pkg::*;

    logic [BANK_W-1:0]    r_bank [NUM_REGS];
    logic [REG_IDX_W-1:0] r_sel;
    logic                 r_updated;
    logic [BANK_W-1:0]    r_prg_rem;
    logic [BANK_W-1:0]    r_chr_base [NUM_PAIRS];
    logic                 r_out_valid;
    t_result              r_result;
    t_result              w_map;

    logic [PAIR_W-1:0]    w_pair;
    logic [DVD_W-1:0]     w_dividend;
    logic [BANK_W-1:0]    w_divisor;
    logic [BANK_W-1:0]    w_rem;
    logic                 w_pc_zero;
    logic                 w_cc_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_bank[i] <= '0;
            end
            r_sel     <= '0;
            r_updated <= 1'b0;
        end else if (i_cmd.accept) begin
            r_updated <= (i_addr_low == ADDR_DATA);
            if (i_addr_low == ADDR_SELECT) begin
                r_sel <= i_write_data[REG_IDX_W-1:0];
            end else if (i_addr_low == ADDR_DATA) begin
                r_bank[r_sel] <= i_write_data;
            end
        end
    end

    // op 0 is the program bank, ops 1..4 the graphics pairs
    assign w_pair     = PAIR_W'(i_cmd.op - 1'b1);
    assign w_dividend = (i_cmd.op == OP_PRG) ? {1'b0, r_bank[REG_PRG]}
                                             : {r_bank[REG_IDX_W'(w_pair)], 1'b0};
    assign w_divisor  = (i_cmd.op == OP_PRG) ? i_cfg.prg_banks
                                             : i_cfg.chr_banks;

    cbm_mod u_mod (
        .i_clk      (i_clk),
        .i_step     (i_cmd.step),
        .i_first    (i_cmd.first),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_rem      (w_rem)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            if (i_cmd.op == OP_PRG) begin
                r_prg_rem <= w_rem;
            end else begin
                r_chr_base[w_pair] <= w_rem;
            end
        end
    end

    assign w_pc_zero = (i_cfg.prg_banks == '0);
    assign w_cc_zero = (i_cfg.chr_banks == '0);

    always_comb begin
        logic [BANK_W:0] w_next;
        w_map.map_updated     = r_updated;
        w_map.prg_switch_bank = w_pc_zero ? '0 : r_prg_rem;
        w_map.prg_fixed_bank  = w_pc_zero ? '0 : BANK_W'(i_cfg.prg_banks - 1'b1);
        w_next = '0;
        for (int i = 0; i < NUM_PAIRS; i++) begin
            // odd slot wraps to bank 0 when the even slot holds the last bank
            w_next = {1'b0, r_chr_base[i]} + 1'b1;
            if (w_cc_zero) begin
                w_map.chr_slot[2*i]   = '0;
                w_map.chr_slot[2*i+1] = '0;
            end else begin
                w_map.chr_slot[2*i]   = r_chr_base[i];
                w_map.chr_slot[2*i+1] = (w_next == {1'b0, i_cfg.chr_banks}) ?
                                        '0 : w_next[BANK_W-1:0];
            end
        end
        if (i_cfg.quad_screen) begin
            w_map.mirror_mode = MIRROR_FOUR;
        end else begin
            w_map.mirror_mode = r_bank[REG_MIRROR][0] ? MIRROR_HORZ : MIRROR_VERT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_result <= w_map;
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_result          = r_result;

endmodule

// ===== rtl/cbm_checker.sv =====
// port-level checks for the bank mapper, bound to the top level
// depends on cartridge_bank_mapper_2k_chr
module cbm_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_prg_switch_bank,
    input  logic [7:0] i_prg_fixed_bank,
    input  logic [7:0] i_chr_slot0,
    input  logic [7:0] i_chr_slot1
);

    // a stalled result stays valid and holds its switchable program bank and first graphics pair
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_prg_switch_bank)
        && $stable(i_chr_slot0) && $stable(i_chr_slot1))
        else $error("stalled result changed");

    // one write in flight at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready && !$rose(i_out_valid))
        else $error("input taken again right after a transfer");

    // switchable program bank does not exceed the fixed (last) program bank
    a_prg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_prg_switch_bank <= i_prg_fixed_bank)
        else $error("program bank beyond last bank");

    // odd slot of the first graphics pair follows its even slot or wraps to bank 0
    a_chr_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_chr_slot1 == 8'd0) || (i_chr_slot1 == i_chr_slot0 + 8'd1))
        else $error("graphics pair out of step");

endmodule

bind cartridge_bank_mapper_2k_chr cbm_checker u_cbm_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in.valid),
    .i_in_ready        (i_in.ready),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_prg_switch_bank (o_out.prg_switch_bank),
    .i_prg_fixed_bank  (o_out.prg_fixed_bank),
    .i_chr_slot0       (o_out.chr_slot0),
    .i_chr_slot1       (o_out.chr_slot1)
);

// ===== tb/sv/tb_cartridge_bank_mapper_2k_chr.sv =====
// testbench for cartridge_bank_mapper_2k_chr: directed table, then random cpu writes
// under several bank-count settings, each map checked against a local bank map predictor
// or a typed table row's expected map; depends on cbm_pkg, cbm_if and the mapper rtl
module tb_cartridge_bank_mapper_2k_chr;
    timeunit 1ns;
    timeprecision 1ps;

    import cbm_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned SETTLE_CYCLES = 20;

    typedef struct {
        bit         cfg_now;
        logic [7:0] prg;
        logic [7:0] chr;
        logic       four;
        logic [7:0] addr;
        logic [7:0] data;
        bit         typed;
        t_result    want;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic pready;

    cbm_in_if  in_if ();
    cbm_out_if out_if ();

    cartridge_bank_mapper_2k_chr i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor state
    logic [7:0] bank_q [NUM_REGS];
    logic [2:0] sel_idx;
    logic [7:0] cnt_prg;
    logic [7:0] cnt_chr;
    logic       four_scr;

    t_result map_q [$];
    t_row    rows [$];
    int      errors;
    int unsigned cycles;
    bit      calm;
    bit      cur_typed;
    t_result cur_want;

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    function automatic t_result apply_write(logic [7:0] a, logic [7:0] d);
        t_result r;
        int unsigned pc;
        int unsigned cc;
        int unsigned b;
        int i;
        r = '0;
        if (a == ADDR_SELECT) begin
            sel_idx = d[2:0];
        end else if (a == ADDR_DATA) begin
            bank_q[sel_idx] = d;
            r.map_updated = 1'b1;
        end
        pc = cnt_prg;
        cc = cnt_chr;
        if (pc != 0) begin
            r.prg_switch_bank = 8'(bank_q[REG_PRG] % pc);
            r.prg_fixed_bank  = 8'(pc - 1);
        end
        for (i = 0; i < NUM_PAIRS; i++) begin
            if (cc != 0) begin
                b = (int'(bank_q[i]) * 2) % cc;
                r.chr_slot[2*i]   = 8'(b);
                r.chr_slot[2*i+1] = 8'((b + 1) % cc);
            end
        end
        if (four_scr)
            r.mirror_mode = MIRROR_FOUR;
        else
            r.mirror_mode = bank_q[REG_MIRROR][0] ? MIRROR_HORZ : MIRROR_VERT;
        return r;
    endfunction

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
        end
    endtask

    // capture input transfers into the predictor, check output transfers
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) begin
                want = apply_write(in_if.addr_low, in_if.write_data);
                if (cur_typed)
                    want = cur_want;
                map_q.push_back(want);
            end
            if (out_if.valid && out_if.ready) begin
                got.map_updated     = out_if.map_updated;
                got.prg_switch_bank = out_if.prg_switch_bank;
                got.prg_fixed_bank  = out_if.prg_fixed_bank;
                got.chr_slot        = {out_if.chr_slot7, out_if.chr_slot6, out_if.chr_slot5,
                                       out_if.chr_slot4, out_if.chr_slot3, out_if.chr_slot2,
                                       out_if.chr_slot1, out_if.chr_slot0};
                got.mirror_mode     = out_if.mirror_mode;
                if (map_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected map transfer, expected none got %p",
                             $time, got);
                end else begin
                    want = map_q.pop_front();
                    check_field("map_updated", want.map_updated, got.map_updated);
                    check_field("prg_switch_bank", want.prg_switch_bank, got.prg_switch_bank);
                    check_field("prg_fixed_bank", want.prg_fixed_bank, got.prg_fixed_bank);
                    check_field("chr_slot", want.chr_slot, got.chr_slot);
                    check_field("mirror_mode", want.mirror_mode, got.mirror_mode);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result side back-pressure
    always @(negedge i_clk) begin
        out_if.ready <= calm || ($urandom_range(0, 99) >= 11);
    end

    task automatic add_row(bit cfg_now, logic [7:0] prg, logic [7:0] chr, logic four,
                           logic [7:0] addr, logic [7:0] data, bit typed, t_result want);
        t_row row;
        row.cfg_now = cfg_now;
        row.prg     = prg;
        row.chr     = chr;
        row.four    = four;
        row.addr    = addr;
        row.data    = data;
        row.typed   = typed;
        row.want    = want;
        rows.push_back(row);
    endtask

    // called at a falling edge; returns at the falling edge after the transfer
    // with valid still high, so the next call or a pause decides its level
    task automatic push_write(logic [7:0] addr, logic [7:0] data, bit typed, t_result want);
        while (!calm && $urandom_range(0, 99) < 11) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.addr_low   <= addr;
        in_if.write_data <= data;
        cur_typed = typed;
        cur_want  = want;
        do @(posedge i_clk); while (!in_if.ready);
        @(negedge i_clk);
    endtask

    task automatic wait_drain();
        in_if.valid <= 1'b0;
        do @(negedge i_clk); while (map_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic apb_write(logic [1:0] idx, logic [7:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= CFG_DATA_W'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_cfg(logic [7:0] prg, logic [7:0] chr, logic four);
        apb_write(CFG_PRG_CNT, prg);
        apb_write(CFG_CHR_CNT, chr);
        apb_write(CFG_QUAD_SCR, {7'd0, four});
        cnt_prg  = prg;
        cnt_chr  = chr;
        four_scr = four;
    endtask

    initial begin
        t_result none;
        t_result reset_map;
        t_result blank_map;
        logic [7:0] p;
        logic [7:0] c;
        logic       f;
        int ph;
        int done_items;
        int pick;
        bit paused;

        none = '0;
        reset_map = '{map_updated: 1'b0, prg_switch_bank: 8'd0, prg_fixed_bank: 8'd1,
                      chr_slot: 64'h0100010001000100, mirror_mode: MIRROR_VERT};
        blank_map = '{map_updated: 1'b0, prg_switch_bank: 8'd0, prg_fixed_bank: 8'd0,
                      chr_slot: 64'h0, mirror_mode: MIRROR_FOUR};

        errors = 0;
        cycles = 0;
        calm = 1'b0;
        cur_typed = 1'b0;
        cur_want = '0;
        in_if.valid = 1'b0;
        in_if.addr_low = '0;
        in_if.write_data = '0;
        out_if.ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        for (int i = 0; i < NUM_REGS; i++) bank_q[i] = '0;
        sel_idx  = '0;
        cnt_prg  = 8'd2;
        cnt_chr  = 8'd8;
        four_scr = 1'b0;

        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // map straight out of reset, then a data write that leaves it unchanged
        add_row(0, 0, 0, 0, ADDR_SELECT, 8'h00, 1, reset_map);
        reset_map.map_updated = 1'b1;
        add_row(0, 0, 0, 0, ADDR_DATA, 8'h00, 1, reset_map);
        // select ignores the upper data bits
        add_row(0, 0, 0, 0, ADDR_SELECT, 8'hFD, 0, none);
        add_row(0, 0, 0, 0, ADDR_DATA, 8'hFF, 0, none);
        add_row(0, 0, 0, 0, ADDR_SELECT, 8'h04, 0, none);
        add_row(0, 0, 0, 0, ADDR_DATA, 8'h01, 0, none);
        add_row(0, 0, 0, 0, ADDR_SELECT, 8'h03, 0, none);
        add_row(0, 0, 0, 0, ADDR_DATA, 8'hFF, 0, none);
        add_row(0, 0, 0, 0, ADDR_SELECT, 8'h07, 0, none);
        add_row(0, 0, 0, 0, ADDR_DATA, 8'hAA, 0, none);
        add_row(0, 0, 0, 0, ADDR_SELECT, 8'h06, 0, none);
        add_row(0, 0, 0, 0, ADDR_DATA, 8'h55, 0, none);
        // offsets other than select and data change nothing
        add_row(0, 0, 0, 0, 8'h02, 8'h12, 0, none);
        add_row(0, 0, 0, 0, 8'hFF, 8'hFF, 0, none);
        add_row(0, 0, 0, 0, 8'h80, 8'h00, 0, none);
        // data write without a fresh select reuses the old index
        add_row(0, 0, 0, 0, ADDR_DATA, 8'h80, 0, none);
        // zero bank counts and four-screen
        add_row(1, 8'd0, 8'd0, 1'b1, 8'h10, 8'h33, 1, blank_map);
        add_row(0, 0, 0, 0, ADDR_SELECT, 8'h05, 0, none);
        add_row(0, 0, 0, 0, ADDR_DATA, 8'h01, 0, none);
        add_row(1, 8'd255, 8'd255, 1'b0, ADDR_SELECT, 8'h00, 0, none);
        add_row(0, 0, 0, 0, ADDR_DATA, 8'hFF, 0, none);
        add_row(0, 0, 0, 0, ADDR_SELECT, 8'h02, 0, none);
        add_row(0, 0, 0, 0, ADDR_DATA, 8'h7F, 0, none);
        // single bank everywhere folds every slot to zero
        blank_map.map_updated = 1'b1;
        add_row(1, 8'd1, 8'd1, 1'b1, ADDR_DATA, 8'h33, 1, blank_map);

        foreach (rows[k]) begin
            if (rows[k].cfg_now) begin
                wait_drain();
                apply_cfg(rows[k].prg, rows[k].chr, rows[k].four);
            end
            push_write(rows[k].addr, rows[k].data, rows[k].typed, rows[k].want);
        end

        for (ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin p = 8'd2;   c = 8'd8;   f = 1'b0; end
                1: begin p = 8'd0;   c = 8'd0;   f = 1'b0; end
                2: begin p = 8'd255; c = 8'd255; f = 1'b1; end
                3: begin p = 8'd0;   c = 8'd255; f = 1'b0; end
                4: begin p = 8'd255; c = 8'd0;   f = 1'b1; end
                default: begin
                    p = 8'($urandom_range(0, 255));
                    c = 8'($urandom_range(0, 255));
                    f = 1'($urandom_range(0, 1));
                end
            endcase
            wait_drain();
            apply_cfg(p, c, f);
            calm = (ph == 3);
            done_items = 0;
            paused = 1'b0;
            while (done_items < 64) begin
                // let the mapper run dry once mid-phase
                if (ph == 5 && !paused && done_items >= 30) begin
                    paused = 1'b1;
                    in_if.valid <= 1'b0;
                    do @(negedge i_clk); while (map_q.size() != 0);
                end
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    push_write(ADDR_SELECT, 8'($urandom_range(0, 255)), 0, none);
                    push_write(ADDR_DATA, 8'($urandom_range(0, 255)), 0, none);
                    done_items += 2;
                end else if (pick < 85) begin
                    push_write(ADDR_DATA, 8'($urandom_range(0, 255)), 0, none);
                    done_items++;
                end else if (pick < 93) begin
                    push_write(ADDR_SELECT, 8'($urandom_range(0, 255)), 0, none);
                    done_items++;
                end else begin
                    push_write(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 0, none);
                    done_items++;
                end
            end
        end
        calm = 1'b0;

        wait_drain();
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
